FILE: rtl/core/sh64_pkg.sv
`timescale 1ns / 1ps

package sh64_pkg;

    // Hash primes
    localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] P3 = 64'h165667B19E3779F9;
    localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;

    // Seed offsets of the accumulators (wrap modulo 2^64)
    localparam logic [63:0] ACC0_OFS = P1 + P2;
    localparam logic [63:0] ACC3_OFS = 64'd0 - P1;

    localparam int unsigned NUM_LANES  = 4;
    localparam int unsigned LANE_BYTES = 8;
    localparam int unsigned STRIPE_BYTES = NUM_LANES * LANE_BYTES;

    // Item modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_FULL  = 2'd1;
    localparam logic [1:0] MODE_PART  = 2'd2;
    localparam logic [1:0] MODE_FINAL = 2'd3;

    typedef logic [NUM_LANES-1:0][63:0] word4_t;

    // Reset contents of the accumulators (seed of zero)
    localparam word4_t ACC_RST = {ACC3_OFS, 64'd0, P2, ACC0_OFS};

    // Per-lane step controls from the sequencer
    typedef struct packed {
        logic mul1_go;   // load first product (operand * P2)
        logic from_acc;  // first operand is the accumulator (finalize)
        logic rot_go;    // add, rotate by 31, hold
        logic zero_add;  // addend is zero (finalize)
        logic mul2_go;   // load second product (held value * P1)
    } lane_ctrl_t;

    // Merge stage status
    typedef struct packed {
        logic busy;
        logic done;
    } merge_stat_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
        rotl64 = (x << r) | (x >> (7'd64 - {1'b0, r}));
    endfunction

endpackage

FILE: rtl/core/stripe_hash64_accumulator.sv
`timescale 1ns / 1ps

// Start and zero-count items are handled in IDLE; a stripe runs the lane round
// (two 64-bit multiplies per lane, four lanes in parallel).
// Finalize: lane round, then four merges and two avalanche multiplies on the
// merge multiplier; the digest is registered at the end. One item at a time.
// Reset: accumulators load their seed-zero values, length and seed clear.
module stripe_hash64_accumulator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [63:0] lane0,
    input  logic [63:0] lane1,
    input  logic [63:0] lane2,
    input  logic [63:0] lane3,
    input  logic [5:0]  byte_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_MERGE = 2'd2;

    localparam logic [5:0] FULL_COUNT = 6'(sh64_pkg::STRIPE_BYTES);

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [1:0]            phase_reg;
    logic [1:0]            phase_next;
    logic                  final_reg;
    logic                  final_next;
    logic                  go_reg;
    logic                  go_next;
    logic [63:0]           seed_reg;
    logic [63:0]           len_reg;
    logic [63:0]           len_next;
    sh64_pkg::word4_t      acc_reg;
    sh64_pkg::word4_t      acc_next;
    sh64_pkg::word4_t      acc_init;
    sh64_pkg::word4_t      lanes_in;
    sh64_pkg::word4_t      lanes_m;
    sh64_pkg::word4_t      rounds;
    logic [sh64_pkg::STRIPE_BYTES-1:0] byte_en;
    logic [5:0]            cnt_eff;
    logic                  accept;
    logic                  is_stripe;
    logic                  take;
    logic                  out_valid_reg;
    logic [63:0]           digest_reg;
    logic [63:0]           merge_digest;
    sh64_pkg::lane_ctrl_t  lane_ctrl;
    sh64_pkg::merge_stat_t merge_stat;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // Byte count, saturated; full stripes count all bytes
    always_comb
    begin
        if (mode == sh64_pkg::MODE_FULL || byte_count > FULL_COUNT)
        begin
            cnt_eff = FULL_COUNT;
        end
        else
        begin
            cnt_eff = byte_count;
        end
    end

    assign is_stripe = (mode == sh64_pkg::MODE_FULL)
                    || (mode == sh64_pkg::MODE_PART && byte_count != 6'd0);

    // Zero the bytes above the count
    assign lanes_in = {lane3, lane2, lane1, lane0};

    always_comb
    begin
        for (int k = 0; k < sh64_pkg::STRIPE_BYTES; k++)
        begin
            byte_en[k] = (6'(k) < cnt_eff);
        end
        for (int i = 0; i < sh64_pkg::NUM_LANES; i++)
        begin
            for (int j = 0; j < sh64_pkg::LANE_BYTES; j++)
            begin
                lanes_m[i][8*j +: 8] = byte_en[i*sh64_pkg::LANE_BYTES + j]
                                     ? lanes_in[i][8*j +: 8] : 8'd0;
            end
        end
    end

    // Seed-derived start values
    assign acc_init = {seed_reg + sh64_pkg::ACC3_OFS, seed_reg,
                       seed_reg + sh64_pkg::P2, seed_reg + sh64_pkg::ACC0_OFS};

    // Lane step controls
    assign lane_ctrl.mul1_go  = accept && (is_stripe || mode == sh64_pkg::MODE_FINAL);
    assign lane_ctrl.from_acc = (mode == sh64_pkg::MODE_FINAL);
    assign lane_ctrl.rot_go   = (state_reg == ST_ROUND) && (phase_reg == 2'd1);
    assign lane_ctrl.zero_add = final_reg;
    assign lane_ctrl.mul2_go  = (state_reg == ST_ROUND) && (phase_reg == 2'd2);

    genvar g;
    generate
        for (g = 0; g < sh64_pkg::NUM_LANES; g++)
        begin : g_lane
            sh64_lane u_lane (
                .clk   (clk),
                .ctrl  (lane_ctrl),
                .data  (lanes_m[g]),
                .acc   (acc_reg[g]),
                .round (rounds[g])
            );
        end
    endgenerate

    assign take = !out_valid_reg || out_ready;

    sh64_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go_reg),
        .take     (take),
        .acc      (acc_reg),
        .round    (rounds),
        .byte_len (len_reg),
        .stat     (merge_stat),
        .digest   (merge_digest)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        final_next = final_reg;
        go_next    = 1'b0;
        len_next   = len_reg;
        acc_next   = acc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == sh64_pkg::MODE_START)
                    begin
                        acc_next = acc_init;
                        len_next = 64'd0;
                    end
                    else if (mode == sh64_pkg::MODE_FINAL)
                    begin
                        final_next = 1'b1;
                        phase_next = 2'd1;
                        state_next = ST_ROUND;
                    end
                    else if (is_stripe)
                    begin
                        len_next   = len_reg + {58'd0, cnt_eff};
                        final_next = 1'b0;
                        phase_next = 2'd1;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_ROUND:
            begin
                if (phase_reg == 2'd3)
                begin
                    phase_next = 2'd0;
                    if (final_reg)
                    begin
                        go_next    = 1'b1;
                        state_next = ST_MERGE;
                    end
                    else
                    begin
                        acc_next   = rounds;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    phase_next = phase_reg + 2'd1;
                end
            end
            ST_MERGE:
            begin
                if (merge_stat.done && take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 2'd0;
            final_reg     <= 1'b0;
            go_reg        <= 1'b0;
            seed_reg      <= 64'd0;
            len_reg       <= 64'd0;
            acc_reg       <= sh64_pkg::ACC_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            final_reg <= final_next;
            go_reg    <= go_next;
            len_reg   <= len_next;
            acc_reg   <= acc_next;
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
            end
            if (merge_stat.done && take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (merge_stat.done && take)
        begin
            digest_reg <= merge_digest;
        end
    end

    assign out_valid = out_valid_reg;
    assign digest    = digest_reg;

    // Merge stage only runs while the sequencer waits on it
    a_idle_no_merge: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !merge_stat.busy)
        else $error("merge busy while sequencer idle");

    // A full stripe starts the lane round sequence
    a_stripe_round: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == sh64_pkg::MODE_FULL) |=> (state_reg == ST_ROUND && phase_reg == 2'd1))
        else $error("full stripe did not enter round");

    // A start transaction clears the length
    a_start_len: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == sh64_pkg::MODE_START) |=> (len_reg == 64'd0))
        else $error("length not cleared on start");

    // A digest only comes out of the merge stage
    a_digest_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_MERGE))
        else $error("digest without finalize");

endmodule

FILE: rtl/core/sh64_mul.sv
`timescale 1ns / 1ps

// 64x64 -> low 64 bit multiply, three 32x32 partial products registered,
// summed on the output side.
module sh64_mul (
    input  logic        clk,
    input  logic        load,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] prod
);

    logic [63:0] pp_lo;
    logic [31:0] pp_hl;
    logic [31:0] pp_lh;
    logic [63:0] pp_lo_reg;
    logic [31:0] pp_hl_reg;
    logic [31:0] pp_lh_reg;
    logic [31:0] cross_sum;

    // Partial products
    assign pp_lo = a[31:0] * b[31:0];
    assign pp_hl = a[63:32] * b[31:0];
    assign pp_lh = a[31:0] * b[63:32];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pp_lo_reg <= pp_lo;
            pp_hl_reg <= pp_hl;
            pp_lh_reg <= pp_lh;
        end
    end

    // Final sum, high partials shifted up by 32
    assign cross_sum = pp_hl_reg + pp_lh_reg;
    assign prod      = pp_lo_reg + {cross_sum, 32'd0};

endmodule

FILE: rtl/core/sh64_lane.sv
`timescale 1ns / 1ps

// One lane round: rotl(addend + operand * P2, 31) * P1, four steps.
module sh64_lane (
    input  logic                clk,
    input  sh64_pkg::lane_ctrl_t ctrl,
    input  logic [63:0]         data,
    input  logic [63:0]         acc,
    output logic [63:0]         round
);

    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic        mul_load;
    logic [63:0] prod;
    logic [63:0] addend;
    logic [63:0] rot_reg;

    // Operand select for the shared multiplier
    always_comb
    begin
        if (ctrl.mul2_go)
        begin
            mul_a = rot_reg;
            mul_b = sh64_pkg::P1;
        end
        else
        begin
            mul_a = ctrl.from_acc ? acc : data;
            mul_b = sh64_pkg::P2;
        end
    end

    assign mul_load = ctrl.mul1_go | ctrl.mul2_go;

    sh64_mul u_mul (
        .clk  (clk),
        .load (mul_load),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Accumulate and rotate
    assign addend = ctrl.zero_add ? 64'd0 : acc;

    always_ff @(posedge clk)
    begin
        if (ctrl.rot_go)
        begin
            rot_reg <= sh64_pkg::rotl64(prod + addend, 6'd31);
        end
    end

    // Product holds until the next load
    assign round = prod;

endmodule

FILE: rtl/core/sh64_merge.sv
`timescale 1ns / 1ps

// Finalize: rotate-sum, four merges, length, avalanche. One shared multiplier.
module sh64_merge (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  logic                  take,
    input  sh64_pkg::word4_t      acc,
    input  sh64_pkg::word4_t      round,
    input  logic [63:0]           byte_len,
    output sh64_pkg::merge_stat_t stat,
    output logic [63:0]           digest
);

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_MUL  = 3'd1;
    localparam logic [2:0] M_ADD  = 3'd2;
    localparam logic [2:0] M_AV1  = 3'd3;
    localparam logic [2:0] M_AV2  = 3'd4;
    localparam logic [2:0] M_AV3  = 3'd5;
    localparam logic [2:0] M_DONE = 3'd6;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic [63:0] h_reg;
    logic [63:0] h_next;
    logic [63:0] rot_sum;
    logic [63:0] len_add;
    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic        mul_load;
    logic [63:0] prod;

    // Rotate-sum of the accumulators
    assign rot_sum = sh64_pkg::rotl64(acc[0], 6'd1) + sh64_pkg::rotl64(acc[1], 6'd7)
                   + sh64_pkg::rotl64(acc[2], 6'd12) + sh64_pkg::rotl64(acc[3], 6'd18);

    assign len_add = (idx_reg == 2'd3) ? byte_len : 64'd0;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        h_next     = h_reg;
        mul_a      = h_reg ^ round[idx_reg];
        mul_b      = sh64_pkg::P1;
        mul_load   = 1'b0;
        case (state_reg)
            M_IDLE:
            begin
                if (go)
                begin
                    h_next     = rot_sum;
                    idx_next   = 2'd0;
                    state_next = M_MUL;
                end
            end
            M_MUL:
            begin
                mul_load   = 1'b1;
                state_next = M_ADD;
            end
            M_ADD:
            begin
                h_next = prod + sh64_pkg::P4 + len_add;
                if (idx_reg == 2'd3)
                begin
                    state_next = M_AV1;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = M_MUL;
                end
            end
            M_AV1:
            begin
                mul_a      = h_reg ^ (h_reg >> 33);
                mul_b      = sh64_pkg::P2;
                mul_load   = 1'b1;
                state_next = M_AV2;
            end
            M_AV2:
            begin
                h_next     = prod;
                state_next = M_AV3;
            end
            M_AV3:
            begin
                mul_a      = h_reg ^ (h_reg >> 29);
                mul_b      = sh64_pkg::P3;
                mul_load   = 1'b1;
                state_next = M_DONE;
            end
            M_DONE:
            begin
                if (take)
                begin
                    state_next = M_IDLE;
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    sh64_mul u_mul (
        .clk  (clk),
        .load (mul_load),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
    end

    assign digest    = prod ^ (prod >> 32);
    assign stat.busy = (state_reg != M_IDLE);
    assign stat.done = (state_reg == M_DONE);

endmodule

FILE: test/stripe_hash64_accumulator_tb.sv
`timescale 1ns / 1ps

module stripe_hash64_accumulator_tb;

    import sh64_pkg::*;

    localparam int unsigned SETTLE_CYCLES  = 24;    // longest item (finalize) plus margin
    localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no transaction on either side
    localparam int unsigned HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam logic [63:0] ONES           = '1;

    // Predicts digests from the accepted item stream and checks the results
    class digest_scoreboard;
        logic [63:0] seed_reg;
        logic [63:0] acc [4];
        logic [63:0] msg_len;
        logic [63:0] pending_digests [$];
        int unsigned mismatches;
        int unsigned digests_checked;
        int unsigned mode_count [4];

        function new();
            seed_reg        = '0;
            mismatches      = 0;
            digests_checked = 0;
            foreach (mode_count[i])
                mode_count[i] = 0;
            load_seed();
        endfunction

        function void load_seed();
            acc[0]  = seed_reg + P1 + P2;
            acc[1]  = seed_reg + P2;
            acc[2]  = seed_reg;
            acc[3]  = seed_reg - P1;
            msg_len = '0;
        endfunction

        function logic [63:0] rotl(logic [63:0] x, int unsigned r);
            return (x << r) | (x >> (64 - r));
        endfunction

        // One multiply-add-rotate-multiply round on a lane
        function logic [63:0] lane_round(logic [63:0] a, logic [63:0] lane);
            logic [63:0] t;
            t = a + lane * P2;
            t = rotl(t, 31);
            return t * P1;
        endfunction

        function void absorb(word4_t lanes, logic [63:0] nbytes);
            for (int i = 0; i < 4; i++)
                acc[i] = lane_round(acc[i], lanes[i]);
            msg_len = msg_len + nbytes;
        endfunction

        // Merge the accumulators, add the length, avalanche
        function logic [63:0] compute_digest();
            logic [63:0] h;
            h = rotl(acc[0], 1) + rotl(acc[1], 7) + rotl(acc[2], 12) + rotl(acc[3], 18);
            for (int i = 0; i < 4; i++)
            begin
                h = h ^ lane_round(64'd0, acc[i]);
                h = h * P1 + P4;
            end
            h = h + msg_len;
            h = h ^ (h >> 33);
            h = h * P2;
            h = h ^ (h >> 29);
            h = h * P3;
            h = h ^ (h >> 32);
            return h;
        endfunction

        function void note_item(logic [1:0] m, word4_t lanes, logic [5:0] cnt);
            word4_t      masked;
            int unsigned n;
            int unsigned base;
            mode_count[m]++;
            case (m)
                MODE_START: load_seed();
                MODE_FULL:  absorb(lanes, 64'd32);
                MODE_PART:
                begin
                    n = cnt;
                    // zero count leaves the state alone; counts above a stripe saturate
                    if (n != 0)
                    begin
                        if (n > 32)
                            n = 32;
                        masked = lanes;
                        for (int i = 0; i < 4; i++)
                        begin
                            base = 8 * i;
                            if (n <= base)
                                masked[i] = '0;
                            else if (n - base < 8)
                                masked[i] = masked[i] & ((64'd1 << ((n - base) * 8)) - 64'd1);
                        end
                        absorb(masked, 64'(n));
                    end
                end
                MODE_FINAL: pending_digests.push_back(compute_digest());
            endcase
        endfunction

        function void check_digest(logic [63:0] got);
            logic [63:0] want;
            if (pending_digests.size() == 0)
            begin
                $error("digest %h arrived with no finalize outstanding", got);
                mismatches++;
                return;
            end
            want = pending_digests.pop_front();
            digests_checked++;
            if (got !== want)
            begin
                $error("field digest: expected %h, actual %h", want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [63:0] cfg_wdata  = '0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [1:0]  mode       = MODE_START;
    logic [63:0] lane0      = '0;
    logic [63:0] lane1      = '0;
    logic [63:0] lane2      = '0;
    logic [63:0] lane3      = '0;
    logic [5:0]  byte_count = '0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [63:0] digest;

    digest_scoreboard sb = new();

    bit          no_idle       = 1'b0;
    bit          holding       = 1'b0;
    int unsigned hold_request  = 0;
    int unsigned items_sent    = 0;
    int unsigned seeds_written = 0;
    int unsigned stall_cycles  = 0;

    stripe_hash64_accumulator u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .lane0      (lane0),
        .lane1      (lane1),
        .lane2      (lane2),
        .lane3      (lane3),
        .byte_count (byte_count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digest     (digest)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones; none while no_idle is set
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one input transaction and wait for its acceptance
    task automatic send_item(input logic [1:0] m, input logic [63:0] l0, input logic [63:0] l1,
                             input logic [63:0] l2, input logic [63:0] l3, input logic [5:0] cnt);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        lane0      <= l0;
        lane1      <= l1;
        lane2      <= l2;
        lane3      <= l3;
        byte_count <= cnt;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic send_random(input logic [1:0] m);
        send_item(m, rand_word(), rand_word(), rand_word(), rand_word(),
                  6'($urandom_range(0, 63)));
    endtask

    // Full or partial stripe; partial counts mostly in range, some zero, some oversized
    task automatic send_stripe();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            send_random(MODE_FULL);
        else
            send_item(MODE_PART, rand_word(), rand_word(), rand_word(), rand_word(),
                      (r < 80) ? 6'($urandom_range(1, 32)) :
                      (r < 90) ? 6'($urandom_range(33, 63)) : 6'd0);
    endtask

    // Stop sending, wait out all digests, then let the last stripe finish
    task automatic drain_block();
        in_valid <= 1'b0;
        // let the monitor record the last accepted transaction first
        @(posedge clk);
        while (sb.pending_digests.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.seed_reg = value;
        seeds_written++;
    endtask

    // One seed setting: mostly start/stripes/finalize messages, some noise
    task automatic run_phase(input logic [63:0] s, input bit calm, input int unsigned n_items);
        int unsigned first;
        int unsigned k;
        drain_block();
        write_seed(s);
        no_idle = calm;
        first   = items_sent;
        while (items_sent - first < n_items)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                send_random(MODE_START);
                k = $urandom_range(0, 8);
                repeat (k) send_stripe();
                send_random(MODE_FINAL);
                if ($urandom_range(0, 9) == 0)
                    send_random(MODE_FINAL);
            end
            else
            begin
                send_random(2'($urandom_range(0, 3)));
            end
        end
        no_idle = 1'b0;
    endtask

    // Receiver: random ready with gaps, plus the long hold-off on request
    initial
    begin
        int unsigned n;
        int unsigned g;
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                n            = hold_request;
                hold_request = 0;
                holding      = 1'b1;
                out_ready   <= 1'b0;
                repeat (n) @(posedge clk);
                holding      = 1'b0;
            end
            else
            begin
                g = pick_gap();
                if (g > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    // Transaction monitor: check results, then record accepted inputs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_digest(digest);
            if (in_valid && in_ready)
                sb.note_item(mode, {lane3, lane2, lane1, lane0}, byte_count);
        end
    end

    // Watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int unsigned part_counts [8];
        part_counts = '{1, 7, 8, 9, 31, 32, 33, 63};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state: digest before any start, zero-count partial is a no-op
        send_item(MODE_FINAL, '0, '0, '0, '0, '0);
        send_item(MODE_FULL, '0, '0, '0, '0, 6'd63);
        send_item(MODE_PART, ONES, ONES, ONES, ONES, 6'd0);
        send_item(MODE_FINAL, ONES, ONES, ONES, ONES, 6'd63);

        // All-ones seed: mask boundaries, saturating counts, repeat finalize
        drain_block();
        write_seed(ONES);
        send_random(MODE_START);
        send_item(MODE_FULL, ONES, ONES, ONES, ONES, 6'd0);
        foreach (part_counts[i])
            send_item(MODE_PART, ONES, ONES, ONES, ONES, 6'(part_counts[i]));
        send_random(MODE_FINAL);
        send_random(MODE_FINAL);
        send_random(MODE_START);
        send_random(MODE_FINAL);
        send_item(MODE_PART, {32{2'b10}}, {32{2'b01}}, {32{2'b10}}, {32{2'b01}}, 6'd16);
        send_random(MODE_FINAL);

        // Backpressure: receiver holds off while items keep coming
        drain_block();
        write_seed(rand_word());
        hold_request = HOLD_CYCLES;
        wait (holding);
        send_random(MODE_START);
        repeat (3)
        begin
            send_random(MODE_FULL);
            send_random(MODE_FINAL);
        end

        // Random messages across several seeds, one phase without idling
        run_phase('0, 1'b0, 115);
        run_phase(ONES, 1'b0, 115);
        run_phase(64'h8000_0000_0000_0000, 1'b0, 115);
        run_phase({$urandom, $urandom}, 1'b1, 115);
        run_phase({$urandom, $urandom}, 1'b0, 115);
        run_phase(64'd1, 1'b0, 115);

        drain_block();
        if (sb.pending_digests.size() != 0)
        begin
            $error("%0d digests never arrived", sb.pending_digests.size());
            sb.mismatches++;
        end

        $display("Run covered %0d transactions: %0d start, %0d full, %0d partial, %0d finalize",
                 items_sent, sb.mode_count[MODE_START], sb.mode_count[MODE_FULL],
                 sb.mode_count[MODE_PART], sb.mode_count[MODE_FINAL]);
        $display("%0d seed settings, %0d digests compared, %0d errors",
                 seeds_written, sb.digests_checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
